FILE: hw/rtl/scmp_pkg.sv
// Shared types, constants and character classes for the command message parser.
// No dependencies; used by the channel interfaces and the top level.
package scmp_pkg;

  localparam int MAX_VALUES = 12;
  localparam int MAX_CHARS  = 32;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 16;
  localparam int VIDX_W  = 4;
  localparam int CIDX_W  = 5;
  localparam int VCNT_W  = $clog2(MAX_VALUES + 1);
  localparam int CCNT_W  = $clog2(MAX_CHARS + 1);
  // acc*10 +/- 9 needs four more bits plus one for headroom
  localparam int ACC_W   = VALUE_W + 5;

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-32768);

  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_QMARK  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_BRACKET_OR_END,
    PH_VALUE,
    PH_FIRST_DIGIT,
    PH_DIGITS,
    PH_END,
    PH_STRING,
    PH_COMMA_OR_BRACKET
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_OPCODE,
    ERR_UNEXPECTED,
    ERR_TWO_STRINGS,
    ERR_RANGE,
    ERR_TOO_MANY,
    ERR_STRING_LONG,
    ERR_BAD_STRING
  } err_t;

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) || is_digit(c);
  endfunction

  // alphanumerics plus - _ space ! ? % ( ) [ ] { } & = + * / . , ; : '
  function automatic logic is_string_char(input logic [BYTE_W-1:0] c);
    logic hit;
    case (c)
      8'h2D, 8'h5F, 8'h20, 8'h21, 8'h3F, 8'h25, 8'h28, 8'h29,
      8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h26, 8'h3D, 8'h2B, 8'h2A,
      8'h2F, 8'h2E, 8'h2C, 8'h3B, 8'h3A, 8'h27: hit = 1'b1;
      default: hit = is_alnum(c);
    endcase
    return hit;
  endfunction

endpackage

FILE: hw/rtl/scmp_in_if.sv
// Byte input channel: valid/ready handshake carrying one received character.
// Depends on scmp_pkg for widths.
interface scmp_in_if;
  logic                        valid;
  logic                        ready;
  logic [scmp_pkg::BYTE_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

FILE: hw/rtl/scmp_out_if.sv
// Status output channel: valid/ready handshake carrying one parse result word.
// Depends on scmp_pkg for widths.
interface scmp_out_if;
  logic                                valid;
  logic                                ready;
  logic                                request_done;
  logic [2:0]                          error_code;
  logic [scmp_pkg::BYTE_W-1:0]         opcode;
  logic                                value_valid;
  logic [scmp_pkg::VIDX_W-1:0]         value_index;
  logic signed [scmp_pkg::VALUE_W-1:0] value_out;
  logic                                char_valid;
  logic [scmp_pkg::CIDX_W-1:0]         char_index;
  logic [scmp_pkg::BYTE_W-1:0]         char_out;
  logic [scmp_pkg::VIDX_W-1:0]         value_count;
  logic                                has_text;

  modport source (output valid, output request_done, output error_code, output opcode,
                  output value_valid, output value_index, output value_out,
                  output char_valid, output char_index, output char_out,
                  output value_count, output has_text, input ready);
  modport sink   (input valid, input request_done, input error_code, input opcode,
                  input value_valid, input value_index, input value_out,
                  input char_valid, input char_index, input char_out,
                  input value_count, input has_text, output ready);
endinterface

FILE: hw/rtl/serial_command_message_parser.sv
// Command message parser top level: byte-wise state machine and result register.
// Depends on scmp_pkg, scmp_in_if and scmp_out_if.
//
// Takes one character word per cycle while in_byte.ready is high, and returns
// exactly one registered status word per character. Messages have the form
// OPCODE [ '[' item {',' item} ']' ] NUL, where the opcode is a letter, digit or
// '?', and an item is a signed decimal (-32768..32767) or one quoted string.
// A value is reported on the comma or closing bracket that ends it; each string
// character is reported as it arrives. Any error (error_code non-zero) drops the
// parser back to waiting for an opcode. Throughput is one word per clock: the
// whole state update is a single level of decode feeding the state registers,
// and the result register frees as it is read, so in_byte.ready only falls when
// a result is held and out_status.ready is low. No reset sweep; in_byte.ready is
// held low while rst_n is low, and a word can be taken as soon as rst_n rises.
module serial_command_message_parser (
  input logic        clk,
  input logic        rst_n,
  scmp_in_if.sink    in_byte,
  scmp_out_if.source out_status
);
  import scmp_pkg::*;

  // parser state
  phase_t                    phase_r, phase_nxt;
  logic [BYTE_W-1:0]         opcode_r, opcode_nxt;
  logic signed [VALUE_W-1:0] acc_r, acc_nxt;
  logic                      neg_r, neg_nxt;
  logic [VCNT_W-1:0]         vcnt_r, vcnt_nxt;
  logic [CCNT_W-1:0]         ccnt_r, ccnt_nxt;
  logic                      seen_r, seen_nxt;

  // result register
  logic                      out_valid_r;
  logic                      done_r;
  err_t                      err_r;
  logic [BYTE_W-1:0]         opc_out_r;
  logic                      vvalid_r;
  logic [VIDX_W-1:0]         vindex_r;
  logic signed [VALUE_W-1:0] vout_r;
  logic                      cvalid_r;
  logic [CIDX_W-1:0]         cindex_r;
  logic [BYTE_W-1:0]         cout_r;
  logic [VIDX_W-1:0]         vcount_out_r;
  logic                      text_r;

  // per-byte decode
  logic [BYTE_W-1:0]         c;
  logic                      accept;
  err_t                      err_c;
  logic                      done_c;
  logic                      vvalid_c;
  logic [VIDX_W-1:0]         vindex_c;
  logic signed [VALUE_W-1:0] vout_c;
  logic                      cvalid_c;
  logic [CIDX_W-1:0]         cindex_c;
  logic [BYTE_W-1:0]         cout_c;
  logic [3:0]                digit;
  logic signed [ACC_W-1:0]   acc_ext, digit_ext, acc_x10, acc_next;
  logic                      range_bad;
  logic                      is_sep;
  logic                      opcode_ok;
  logic                      vroom, croom;

  assign c      = in_byte.byte_in;
  assign accept = in_byte.valid && in_byte.ready;
  assign in_byte.ready = rst_n && (!out_valid_r || out_status.ready);

  // digit accumulate: acc*10 +/- d, checked against the 16-bit range
  assign digit     = 4'(c - CH_ZERO);
  assign acc_ext   = ACC_W'(acc_r);
  assign digit_ext = ACC_W'(digit);
  assign acc_x10   = (acc_ext <<< 3) + (acc_ext <<< 1);
  assign acc_next  = neg_r ? (acc_x10 - digit_ext) : (acc_x10 + digit_ext);
  assign range_bad = (acc_next > ACC_MAX) || (acc_next < ACC_MIN);

  assign is_sep    = (c == CH_COMMA) || (c == CH_RBRACK);
  assign opcode_ok = is_alnum(c) || (c == CH_QMARK);
  assign vroom     = vcnt_r < VCNT_W'(MAX_VALUES);
  assign croom     = ccnt_r < CCNT_W'(MAX_CHARS);

  // next phase and error code
  always_comb begin
    err_c     = ERR_NONE;
    phase_nxt = phase_r;
    case (phase_r)
      PH_BRACKET_OR_END: begin
        if (c == CH_LBRACK) phase_nxt = PH_VALUE;
        else if (c == CH_NUL) phase_nxt = PH_OPCODE;
        else err_c = ERR_UNEXPECTED;
      end
      PH_END: begin
        if (c == CH_NUL) phase_nxt = PH_OPCODE;
        else err_c = ERR_UNEXPECTED;
      end
      PH_VALUE: begin
        if (c == CH_MINUS) phase_nxt = PH_FIRST_DIGIT;
        else if (is_digit(c)) phase_nxt = PH_DIGITS;
        else if (c == CH_QUOTE) begin
          if (seen_r) err_c = ERR_TWO_STRINGS;
          else phase_nxt = PH_STRING;
        end else err_c = ERR_UNEXPECTED;
      end
      PH_FIRST_DIGIT, PH_DIGITS: begin
        if (is_digit(c)) begin
          if (range_bad) err_c = ERR_RANGE;
          else phase_nxt = PH_DIGITS;
        end else if ((phase_r == PH_DIGITS) && is_sep) begin
          if (vroom) phase_nxt = (c == CH_COMMA) ? PH_VALUE : PH_END;
          else err_c = ERR_TOO_MANY;
        end else err_c = ERR_UNEXPECTED;
      end
      PH_STRING: begin
        if (c == CH_QUOTE) phase_nxt = PH_COMMA_OR_BRACKET;
        else if ((c == CH_NUL) || !is_string_char(c)) err_c = ERR_BAD_STRING;
        else if (!croom) err_c = ERR_STRING_LONG;
      end
      PH_COMMA_OR_BRACKET: begin
        if (c == CH_COMMA) phase_nxt = PH_VALUE;
        else if (c == CH_RBRACK) phase_nxt = PH_END;
        else err_c = ERR_UNEXPECTED;
      end
      default: begin
        if (opcode_ok) phase_nxt = PH_BRACKET_OR_END;
        else err_c = ERR_OPCODE;
      end
    endcase
    if (err_c != ERR_NONE) phase_nxt = PH_OPCODE;
  end

  // datapath updates and result fields
  always_comb begin
    opcode_nxt = opcode_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    vcnt_nxt   = vcnt_r;
    ccnt_nxt   = ccnt_r;
    seen_nxt   = seen_r;
    done_c     = 1'b0;
    vvalid_c   = 1'b0;
    vindex_c   = '0;
    vout_c     = '0;
    cvalid_c   = 1'b0;
    cindex_c   = '0;
    cout_c     = '0;
    case (phase_r)
      PH_BRACKET_OR_END, PH_END: begin
        done_c = (c == CH_NUL);
      end
      PH_VALUE: begin
        if (c == CH_MINUS) begin
          acc_nxt = '0;
          neg_nxt = 1'b1;
        end else if (is_digit(c)) begin
          acc_nxt = VALUE_W'(digit);
          neg_nxt = 1'b0;
        end
      end
      PH_FIRST_DIGIT, PH_DIGITS: begin
        if (is_digit(c)) begin
          if (!range_bad) acc_nxt = VALUE_W'(acc_next);
        end else if ((phase_r == PH_DIGITS) && is_sep && vroom) begin
          vvalid_c = 1'b1;
          vindex_c = VIDX_W'(vcnt_r);
          vout_c   = acc_r;
          vcnt_nxt = VCNT_W'(vcnt_r + 1'b1);
        end
      end
      PH_STRING: begin
        if (c == CH_QUOTE) seen_nxt = 1'b1;
        else if ((c != CH_NUL) && is_string_char(c) && croom) begin
          cvalid_c = 1'b1;
          cindex_c = CIDX_W'(ccnt_r);
          cout_c   = c;
          ccnt_nxt = CCNT_W'(ccnt_r + 1'b1);
        end
      end
      PH_COMMA_OR_BRACKET: begin
        done_c = 1'b0;
      end
      default: begin
        if (opcode_ok) begin
          opcode_nxt = c;
          vcnt_nxt   = '0;
          ccnt_nxt   = '0;
          seen_nxt   = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPCODE;
      opcode_r    <= '0;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      vcnt_r      <= '0;
      ccnt_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        opcode_r <= opcode_nxt;
        acc_r    <= acc_nxt;
        neg_r    <= neg_nxt;
        vcnt_r   <= vcnt_nxt;
        ccnt_r   <= ccnt_nxt;
        seen_r   <= seen_nxt;
        out_valid_r <= 1'b1;
      end else if (out_status.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      done_r       <= done_c;
      err_r        <= err_c;
      opc_out_r    <= opcode_nxt;
      vvalid_r     <= vvalid_c;
      vindex_r     <= vindex_c;
      vout_r       <= vout_c;
      cvalid_r     <= cvalid_c;
      cindex_r     <= cindex_c;
      cout_r       <= cout_c;
      vcount_out_r <= VIDX_W'(vcnt_nxt);
      text_r       <= seen_nxt;
    end
  end

  assign out_status.valid        = out_valid_r;
  assign out_status.request_done = done_r;
  assign out_status.error_code   = err_r;
  assign out_status.opcode       = opc_out_r;
  assign out_status.value_valid  = vvalid_r;
  assign out_status.value_index  = vindex_r;
  assign out_status.value_out    = vout_r;
  assign out_status.char_valid   = cvalid_r;
  assign out_status.char_index   = cindex_r;
  assign out_status.char_out     = cout_r;
  assign out_status.value_count  = vcount_out_r;
  assign out_status.has_text     = text_r;

  // checks
  a_vcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= VCNT_W'(MAX_VALUES))
    else $error("value count beyond limit");

  a_ccnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ccnt_r <= CCNT_W'(MAX_CHARS))
    else $error("string length beyond limit");

  a_err_resync: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (err_c != ERR_NONE)) |=> (phase_r == PH_OPCODE))
    else $error("parser not back at opcode wait after error");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> ((err_r == ERR_NONE) && !vvalid_r && !cvalid_r))
    else $error("completed message word carries error or data");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(vvalid_r && cvalid_r))
    else $error("value and character reported in one word");

endmodule
